/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/dmat_pkg.sv */
// Shared constants and types for the magnitude adder.
package dmat_pkg;
    localparam int unsigned WordW = 64;
    localparam int unsigned ExpW = 11;
    localparam int unsigned FracW = 52;
    localparam int unsigned MantW = FracW + 1;
    localparam int unsigned ShiftW = 6;
    localparam logic [ShiftW-1:0] MaxShift = 6'd54;

    // Ordered operands and shift amount after the first stage.
    typedef struct packed {
        logic             bypass;
        logic [WordW-1:0] bypass_word;
        logic [ExpW-1:0]  exp_big;
        logic [MantW-1:0] mant_big;
        logic [MantW-1:0] mant_small;
        logic [ShiftW-1:0] shift;
    } t_align;

    // Shifted operands after the second stage.
    typedef struct packed {
        logic             bypass;
        logic [WordW-1:0] bypass_word;
        logic [ExpW-1:0]  exp_big;
        logic [MantW-1:0] mant_big;
        logic [MantW-1:0] mant_small;
    } t_shifted;
endpackage

/* hdl/dmat_core.sv */
// Three-stage datapath: compare and swap, align shift, add and pack.
module dmat_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [dmat_pkg::WordW-1:0]  i_a,
    input  logic [dmat_pkg::WordW-1:0]  i_b,
    output logic                        o_valid,
    output logic [dmat_pkg::WordW-1:0]  o_sum
);
    logic [2:0] r_vld;
    dmat_pkg::t_align   r_s1, n_s1;
    dmat_pkg::t_shifted r_s2, n_s2;
    logic [dmat_pkg::WordW-1:0] r_out, n_out;

    // Stage one: unpack, zero test, order by exponent.
    always_comb begin
        logic [dmat_pkg::ExpW-1:0] ea, eb, d;
        logic za, zb;
        ea = i_a[62:52];
        eb = i_b[62:52];
        za = (ea == '0) && (i_a[51:0] == '0);
        zb = (eb == '0) && (i_b[51:0] == '0);
        n_s1.bypass = za || zb;
        n_s1.bypass_word = za ? i_b : i_a;
        if (ea >= eb) begin
            d = ea - eb;
            n_s1.exp_big = ea;
            n_s1.mant_big = {1'b1, i_a[51:0]};
            n_s1.mant_small = {1'b1, i_b[51:0]};
        end else begin
            d = eb - ea;
            n_s1.exp_big = eb;
            n_s1.mant_big = {1'b1, i_b[51:0]};
            n_s1.mant_small = {1'b1, i_a[51:0]};
        end
        // Differences of 54 and up all clear the mantissa.
        n_s1.shift = (d >= 11'(dmat_pkg::MaxShift)) ? dmat_pkg::MaxShift
                                                    : d[dmat_pkg::ShiftW-1:0];
    end

    // Stage two: barrel shift of the smaller mantissa.
    always_comb begin
        n_s2.bypass = r_s1.bypass;
        n_s2.bypass_word = r_s1.bypass_word;
        n_s2.exp_big = r_s1.exp_big;
        n_s2.mant_big = r_s1.mant_big;
        n_s2.mant_small = r_s1.mant_small >> r_s1.shift;
    end

    // Stage three: add, normalize a carry, pack with sign zero.
    always_comb begin
        logic [dmat_pkg::MantW:0] s;
        logic [dmat_pkg::ExpW:0] e;
        s = {1'b0, r_s2.mant_big} + {1'b0, r_s2.mant_small};
        e = {1'b0, r_s2.exp_big} + {{dmat_pkg::ExpW{1'b0}}, s[dmat_pkg::MantW]};
        if (s[dmat_pkg::MantW]) begin
            n_out = {e, s[52:1]};
        end else begin
            n_out = {e, s[51:0]};
        end
        if (r_s2.bypass) begin
            n_out = r_s2.bypass_word;
        end
    end

    // Valid bits advance with the data when the pipe moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[2];
    assign o_sum = r_out;
endmodule

/* hdl/double_magnitude_add_truncating_unit.sv */
// Top level of the pipelined binary64 magnitude adder.
// Usage:
// The slave channel carries an operand pair per transfer; the master channel
// carries one packed sum per accepted pair, in order.
// Each operand contributes its implicit one; the smaller mantissa is shifted
// down by the exponent gap and the sum is truncated, never rounded.
// A zero operand passes the other operand through unchanged.
// The result passes through three register stages (compare, barrel shift,
// add and pack) after the input transfer; one pair can be accepted in every
// cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipe holds and
// s_axis_tready drops until that result is taken, so nothing is lost or
// repeated.
// Synchronous active-low reset clears all valid bits; data registers are
// left as they are.
module double_magnitude_add_truncating_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // operand_a [63:0], operand_b [127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata   // sum_word [63:0]
);
    logic w_adv;
    logic w_valid;

    // The pipe moves whenever the output slot is free or being drained.
    assign w_adv = !w_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    dmat_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (s_axis_tvalid),
        .i_a     (s_axis_tdata[63:0]),
        .i_b     (s_axis_tdata[127:64]),
        .o_valid (w_valid),
        .o_sum   (m_axis_tdata)
    );

    assign m_axis_tvalid = w_valid;
endmodule

/* hdl/dmat_checker.sv */
// Port-level assertions for the magnitude adder, with their bind.
`include "assert_macros.svh"
module dmat_port_assertions (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata
);
    logic w_stall;
    logic w_in_xfer;

    // A result is waiting and the receiver refuses it.
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // A stalled result keeps its data.
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, w_stall |=> $stable(m_axis_tdata), "output changed")
    // Input is refused only while a result waits.
    `ASSERT_CLK(a_rdy, i_clk, i_rst_n, !s_axis_tready |-> w_stall, "input refused with no stall")
    // Nothing valid comes out right after reset.
    `ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
    // A transfer in reaches the output when the receiver stays ready throughout.
    `ASSERT_CLK(a_lat, i_clk, i_rst_n, w_in_xfer && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid, "result missing")
endmodule

bind double_magnitude_add_truncating_unit dmat_port_assertions u_dmat_port_assertions (.*);
